/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files of the chirp generator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge out of reset.
`define CHK_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When trig holds, expr must hold in the same cycle.
`define CHK_SAME(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
        else $error(msg);

// When trig holds, expr must hold in the next cycle.
`define CHK_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

/* hdl/lcsg_pkg.sv */
// Shared constants, types and the CORDIC angle table of the chirp generator.
// No dependencies; every module of the block imports this package.
package lcsg_pkg;

    localparam int TIME_BITS      = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS    = 20;

    localparam int IN_BITS       = 32;
    localparam int OUT_DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_ADDR_BITS = 6;

    // Phase bits kept after truncation: two quadrant bits and the table address.
    localparam int PHASE_KEEP = SINE_ADDR_BITS + 2;
    localparam int RESID_BITS = 30;

    localparam int CORDIC_STEPS = 24;
    localparam int STEP_BITS    = 5;
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INIT = 34'sd652032874;

    localparam int AMP_BITS    = 16;
    localparam int PROD_W      = CORDIC_W + AMP_BITS + 1;
    localparam int ROUND_SHIFT = 27;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_WINDOW_START  = 3'd0;
    localparam logic [2:0] REG_WINDOW_LENGTH = 3'd1;
    localparam logic [2:0] REG_START_FREQ    = 3'd2;
    localparam logic [2:0] REG_HALF_RATE     = 3'd3;
    localparam logic [2:0] REG_AMPLITUDE     = 3'd4;

    // Quadrant codes taken from the top two phase bits.
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    typedef struct packed {
        logic [31:0] window_start;
        logic [31:0] window_length;
        logic [31:0] start_freq;
        logic [63:0] half_rate;
        logic [AMP_BITS-1:0] amplitude;
    } cfg_t;

    typedef struct packed {
        logic [1:0]            quad;
        logic [RESID_BITS-1:0] resid;
        logic                  active;
    } phase_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        logic [1:0]                 quad;
        logic                       active;
    } cord_t;

    // Rotation angle of each CORDIC step in 2^-32 turns.
    function automatic logic signed [CORDIC_W-1:0] atan_turns(input logic [STEP_BITS-1:0] step);
        logic signed [CORDIC_W-1:0] a;
        case (step)
            5'd0:    a = 34'sd536870912;
            5'd1:    a = 34'sd316933406;
            5'd2:    a = 34'sd167458907;
            5'd3:    a = 34'sd85004756;
            5'd4:    a = 34'sd42667331;
            5'd5:    a = 34'sd21354465;
            5'd6:    a = 34'sd10679838;
            5'd7:    a = 34'sd5340245;
            5'd8:    a = 34'sd2670163;
            5'd9:    a = 34'sd1335087;
            5'd10:   a = 34'sd667544;
            5'd11:   a = 34'sd333772;
            5'd12:   a = 34'sd166886;
            5'd13:   a = 34'sd83443;
            5'd14:   a = 34'sd41722;
            5'd15:   a = 34'sd20861;
            5'd16:   a = 34'sd10430;
            5'd17:   a = 34'sd5215;
            5'd18:   a = 34'sd2608;
            5'd19:   a = 34'sd1304;
            5'd20:   a = 34'sd652;
            5'd21:   a = 34'sd326;
            5'd22:   a = 34'sd163;
            5'd23:   a = 34'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* hdl/lcsg_regs.sv */
// Configuration register file with its APB-style access port.
// Depends on lcsg_pkg for the register indexes and the cfg_t bundle.
module lcsg_regs import lcsg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[CFG_ADDR_BITS-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_start  <= 32'd0;
            cfg_reg.window_length <= 32'd1;
            cfg_reg.start_freq    <= 32'd0;
            cfg_reg.half_rate     <= 64'd0;
            cfg_reg.amplitude     <= 16'd4096;
        end
        else if (wr_en)
        begin
            case (index)
                REG_WINDOW_START:  cfg_reg.window_start  <= pwdata[31:0];
                REG_WINDOW_LENGTH: cfg_reg.window_length <= pwdata[31:0];
                REG_START_FREQ:    cfg_reg.start_freq    <= pwdata[31:0];
                REG_HALF_RATE:     cfg_reg.half_rate     <= pwdata;
                REG_AMPLITUDE:     cfg_reg.amplitude     <= pwdata[AMP_BITS-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_WINDOW_START:  prdata = CFG_DATA_BITS'(cfg_reg.window_start);
            REG_WINDOW_LENGTH: prdata = CFG_DATA_BITS'(cfg_reg.window_length);
            REG_START_FREQ:    prdata = CFG_DATA_BITS'(cfg_reg.start_freq);
            REG_HALF_RATE:     prdata = cfg_reg.half_rate;
            REG_AMPLITUDE:     prdata = CFG_DATA_BITS'(cfg_reg.amplitude);
            default:           prdata = '0;
        endcase
    end

endmodule

/* hdl/lcsg_phase.sv */
// Front pipeline: window test, tau and the quadratic phase, five register stages.
// Depends on lcsg_pkg for cfg_t and phase_t.
module lcsg_phase import lcsg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [IN_BITS-1:0] time_ticks,
    output logic               out_valid,
    input  logic               out_ready,
    output phase_t             out_data
);

    localparam logic [RESID_BITS-1:0] RESID_MASK =
        ~RESID_BITS'((64'd1 << (32 - PHASE_KEEP)) - 64'd1);

    // Stage valid bits and the ready chain; a stage loads when empty or draining.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
            if (s5_ready) s5_valid_reg <= s4_valid_reg;
        end
    end

    // Stage 1: window test and tau.
    logic [63:0]          t_ext, st_ext, len_ext;
    logic [TIME_BITS-1:0] t_w, st_w, len_w, tau_next;
    logic                 active_next;
    logic [TIME_BITS-1:0] tau_reg;
    logic                 s1_active_reg;

    assign t_ext       = 64'(time_ticks);
    assign st_ext      = 64'(cfg.window_start);
    assign len_ext     = 64'(cfg.window_length);
    assign t_w         = t_ext[TIME_BITS-1:0];
    assign st_w        = st_ext[TIME_BITS-1:0];
    assign len_w       = len_ext[TIME_BITS-1:0];
    assign tau_next    = t_w - st_w;
    assign active_next = (t_w >= st_w) && (tau_next < len_w);

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            tau_reg       <= tau_next;
            s1_active_reg <= active_next;
        end
    end

    // Stage 2: start_freq * tau (low word only) and the partial products of tau^2.
    logic [63:0] tau_ext;
    logic [31:0] tau_lo, tau_hi;
    logic [63:0] sft_full, tll_next, cross_full;
    logic [31:0] sf_tau2_reg, cross_reg;
    logic [63:0] tll_reg;
    logic        s2_active_reg;

    assign tau_ext    = 64'(tau_reg);
    assign tau_lo     = tau_ext[31:0];
    assign tau_hi     = tau_ext[63:32];
    assign sft_full   = cfg.start_freq * tau_lo;
    assign tll_next   = tau_lo * tau_lo;
    assign cross_full = tau_hi * tau_lo;

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            sf_tau2_reg   <= sft_full[31:0];
            tll_reg       <= tll_next;
            cross_reg     <= cross_full[31:0];
            s2_active_reg <= s1_active_reg;
        end
    end

    // Stage 3: tau^2 modulo 2^64.
    logic [63:0] tausq_next, tausq_reg;
    logic [31:0] sf_tau3_reg;
    logic        s3_active_reg;

    assign tausq_next = tll_reg + {cross_reg[30:0], 1'b0, 32'd0};

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            tausq_reg     <= tausq_next;
            sf_tau3_reg   <= sf_tau2_reg;
            s3_active_reg <= s2_active_reg;
        end
    end

    // Stage 4: half_rate * tau^2 modulo 2^64 from 32-bit partial products.
    logic [63:0] ll_next, x1_full, x2_full;
    logic [63:0] ll_reg;
    logic [31:0] x1_reg, x2_reg, sf_tau4_reg;
    logic        s4_active_reg;

    assign ll_next = cfg.half_rate[31:0] * tausq_reg[31:0];
    assign x1_full = cfg.half_rate[63:32] * tausq_reg[31:0];
    assign x2_full = cfg.half_rate[31:0] * tausq_reg[63:32];

    always_ff @(posedge clk)
    begin
        if (s4_ready)
        begin
            ll_reg        <= ll_next;
            x1_reg        <= x1_full[31:0];
            x2_reg        <= x2_full[31:0];
            sf_tau4_reg   <= sf_tau3_reg;
            s4_active_reg <= s3_active_reg;
        end
    end

    // Stage 5: upper phase word, truncated to the kept bits.
    logic [31:0] phase_hi;
    phase_t      out_reg;

    assign phase_hi = sf_tau4_reg + ll_reg[63:32] + x1_reg + x2_reg;

    always_ff @(posedge clk)
    begin
        if (s5_ready)
        begin
            out_reg.quad   <= phase_hi[31:30];
            out_reg.resid  <= phase_hi[29:0] & RESID_MASK;
            out_reg.active <= s4_active_reg;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_data  = out_reg;

endmodule

/* hdl/lcsg_cordic_cell.sv */
// One CORDIC rotation step with its own pipeline register and valid bit.
// Depends on lcsg_pkg for cord_t and the angle table.
module lcsg_cordic_cell import lcsg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [STEP_BITS-1:0] step,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cord_t                in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cord_t                out_data
);

    logic                       valid_reg, valid_next;
    cord_t                      data_reg, data_next;
    logic signed [CORDIC_W-1:0] x_in, y_in, z_in, dx, dy, angle;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        x_in      = in_data.x;
        y_in      = in_data.y;
        z_in      = in_data.z;
        dx        = y_in >>> step;
        dy        = x_in >>> step;
        angle     = atan_turns(step);
        data_next = in_data;
        if (!z_in[CORDIC_W-1])
        begin
            data_next.x = x_in - dx;
            data_next.y = y_in + dy;
            data_next.z = z_in - angle;
        end
        else
        begin
            data_next.x = x_in + dx;
            data_next.y = y_in - dy;
            data_next.z = z_in + angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hdl/lcsg_scale.sv */
// Back end: quadrant mapping, amplitude scaling, rounding and saturation.
// Depends on lcsg_pkg; its second stage is the output register of the block.
module lcsg_scale import lcsg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [AMP_BITS-1:0]           amplitude,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cord_t                         in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] in_phase,
    output logic signed [SAMPLE_BITS-1:0] quadrature,
    output logic                          active
);

    localparam logic signed [PROD_W-1:0] ROUND_HALF =
        PROD_W'(64'd1 << (ROUND_SHIFT - 1));
    localparam logic signed [PROD_W-1:0] SAT_HI =
        PROD_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;

    logic a_valid_reg, b_valid_reg, a_ready, b_ready;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready) a_valid_reg <= in_valid;
            if (b_ready) b_valid_reg <= a_valid_reg;
        end
    end

    // Stage A: rotate into the quadrant and multiply by the amplitude.
    logic signed [CORDIC_W-1:0] c_in, s_in, ci, si;
    logic signed [AMP_BITS:0]   amp_s;
    logic signed [PROD_W-1:0]   prod_i_next, prod_q_next, prod_i_reg, prod_q_reg;
    logic                       a_active_reg;

    always_comb
    begin
        c_in = in_data.x;
        s_in = in_data.y;
        case (in_data.quad)
            QUAD_I:
            begin
                ci = c_in;
                si = s_in;
            end
            QUAD_II:
            begin
                ci = -s_in;
                si = c_in;
            end
            QUAD_III:
            begin
                ci = -c_in;
                si = -s_in;
            end
            default:
            begin
                ci = s_in;
                si = -c_in;
            end
        endcase
        amp_s       = signed'({1'b0, amplitude});
        prod_i_next = ci * amp_s;
        prod_q_next = si * amp_s;
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            prod_i_reg   <= prod_i_next;
            prod_q_reg   <= prod_q_next;
            a_active_reg <= in_data.active;
        end
    end

    // Stage B: round half up to 15 fraction bits and clamp.
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] r;
        r = (p + ROUND_HALF) >>> ROUND_SHIFT;
        if (r > SAT_HI)
            r = SAT_HI;
        else if (r < SAT_LO)
            r = SAT_LO;
        return SAMPLE_BITS'(r);
    endfunction

    logic signed [SAMPLE_BITS-1:0] in_phase_next, quadrature_next;
    logic signed [SAMPLE_BITS-1:0] in_phase_reg, quadrature_reg;
    logic                          active_reg;

    // Samples outside the window leave as zero.
    assign in_phase_next   = a_active_reg ? round_sat(prod_i_reg) : '0;
    assign quadrature_next = a_active_reg ? round_sat(prod_q_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            in_phase_reg   <= in_phase_next;
            quadrature_reg <= quadrature_next;
            active_reg     <= a_active_reg;
        end
    end

    assign out_valid  = b_valid_reg;
    assign in_phase   = in_phase_reg;
    assign quadrature = quadrature_reg;
    assign active     = active_reg;

endmodule

/* hdl/lfm_chirp_sample_generator.sv */
// Top level of the LFM chirp sample generator: registers, phase pipeline,
// CORDIC cell chain and output scaling. Depends on lcsg_pkg and all lcsg_* modules.
//
//  Channel   | Direction | Signals                          | Transfer when
//  ----------+-----------+----------------------------------+------------------------------
//  s_*       | in        | tvalid, tready, tdata (time)     | s_tvalid && s_tready
//  m_*       | out       | tvalid, tready, tdata, tuser     | m_tvalid && m_tready
//  APB       | in/out    | psel, penable, pwrite, paddr ... | psel && penable && pwrite
//
// One sample per clock is sustained while the output is not stalled; the pipeline has five
// phase stages, 24 CORDIC cells and two scaling stages. Every stage holds its own valid bit and
// loads whenever it is empty or its successor takes its item, so a stall on the
// output backs up stage by stage and bubbles are squeezed out. Reset clears all
// valid bits and loads the register defaults; no clearing pass is needed.
module lfm_chirp_sample_generator import lcsg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [31:0] time_ticks
    input  logic [IN_BITS-1:0]       s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [19:0] in_phase, [39:20] quadrature
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    // [0] active
    output logic [0:0]               m_tuser,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    cfg_t   cfg;
    phase_t ph_data;
    logic   ph_valid;

    logic  chain_valid [CORDIC_STEPS+1];
    logic  chain_ready [CORDIC_STEPS+1];
    cord_t chain_data  [CORDIC_STEPS+1];

    logic signed [SAMPLE_BITS-1:0] in_phase, quadrature;
    logic                          active;

    lcsg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcsg_phase u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .time_ticks (s_tdata),
        .out_valid  (ph_valid),
        .out_ready  (chain_ready[0]),
        .out_data   (ph_data)
    );

    // The rotation starts on the gain-corrected x axis with the residual angle.
    assign chain_valid[0]       = ph_valid;
    assign chain_data[0].x      = CORDIC_GAIN_INIT;
    assign chain_data[0].y      = '0;
    assign chain_data[0].z      = CORDIC_W'(ph_data.resid);
    assign chain_data[0].quad   = ph_data.quad;
    assign chain_data[0].active = ph_data.active;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        lcsg_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (STEP_BITS'(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    lcsg_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .amplitude  (cfg.amplitude),
        .in_valid   (chain_valid[CORDIC_STEPS]),
        .in_ready   (chain_ready[CORDIC_STEPS]),
        .in_data    (chain_data[CORDIC_STEPS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .in_phase   (in_phase),
        .quadrature (quadrature),
        .active     (active)
    );

    assign m_tdata    = OUT_DATA_BITS'({quadrature, in_phase});
    assign m_tuser[0] = active;

endmodule

/* hdl/lcsg_checker.sv */
// Port-level checker of the chirp generator, attached to the top level by bind.
// Depends on lcsg_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module lcsg_checker import lcsg_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic [IN_BITS-1:0]       s_tdata,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OUT_DATA_BITS-1:0] m_tdata,
    input logic [0:0]               m_tuser,
    input logic                     psel,
    input logic                     penable,
    input logic                     pwrite,
    input logic [CFG_ADDR_BITS-1:0] paddr,
    input logic [CFG_DATA_BITS-1:0] pwdata,
    input logic [CFG_DATA_BITS-1:0] prdata,
    input logic                     pready
);

    // A stalled result keeps its value until the transfer.
    `CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    // A sample outside the window carries zero data.
    `CHK_SAME(a_inactive_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "inactive sample is not zero")
    // With the output register empty, every stage can load, so the input is ready.
    `CHK_SAME(a_drain_ready, !m_tvalid, s_tready, "input stalled with empty output")
    `CHK_ALWAYS(a_pready, pready, "register port not ready")

endmodule

bind lfm_chirp_sample_generator lcsg_checker u_checker (.*);

/* bench/testbench.sv */
// Self-checking testbench for the LFM chirp sample generator (lfm_chirp_sample_generator).
// Holds its own fixed-point chirp predictor, drives the time stream, APB registers and output
// backpressure. Depends only on lcsg_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
    import lcsg_pkg::*;

    localparam int LATENCY    = 31;
    localparam int LONG_HOLD  = 300;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 220;
    localparam int N_ROWS     = 41;

    localparam longint X_START = 652032874;
    localparam longint SAT_HI  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO  = -(longint'(1) <<< (SAMPLE_BITS - 1));
    localparam longint ARC_TURNS [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // Register slots that decode to nothing; NO_REG only fills the index of time rows.
    localparam logic [2:0] REG_SPARE_LOW  = 3'd5;
    localparam logic [2:0] REG_SPARE_HIGH = 3'd7;
    localparam logic [2:0] NO_REG         = 3'd0;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_phase;
        logic signed [SAMPLE_BITS-1:0] quadrature;
        logic                          active;
    } sample_t;

    typedef enum logic {ROW_WRITE, ROW_TIME} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [63:0] value;
        logic        typed;
        sample_t     want;
    } stim_row_t;

    localparam sample_t NO_SAMPLE      = '0;
    localparam sample_t FULL_SCALE_COS = '{in_phase: 20'sd32768, quadrature: 20'sd0,
                                           active: 1'b1};

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // [31:0] time_ticks
    logic [IN_BITS-1:0]       s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // [19:0] in_phase, [39:20] quadrature
    logic [OUT_DATA_BITS-1:0] m_tdata;
    // [0] active
    logic [0:0]               m_tuser;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Register image kept in step with every APB write.
    logic [31:0] cur_start  = 32'd0;
    logic [31:0] cur_length = 32'd1;
    logic [31:0] cur_freq   = 32'd0;
    logic [63:0] cur_half_rate = 64'd0;
    logic [15:0] cur_amp    = 16'd4096;

    sample_t samples_due [$];
    int      fails = 0;
    int      checked = 0;
    int      reg_writes = 0;
    int      stall_pct = 0;
    int      hold_asked = 0;
    int      hold_taken = 0;
    int      hold_left = 0;

    stim_row_t directed_rows [0:N_ROWS-1] = '{
        '{ROW_TIME,  NO_REG,            64'd0,                  1'b1, FULL_SCALE_COS},
        '{ROW_TIME,  NO_REG,            64'd1,                  1'b1, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'hFFFF_FFFF,          1'b1, NO_SAMPLE},
        '{ROW_WRITE, REG_WINDOW_START,  64'd100,                1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 64'd50,                 1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_START_FREQ,    64'h4000_0000,          1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'd99,                 1'b1, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'd100,                1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'd101,                1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'd102,                1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'd103,                1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'd149,                1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'd150,                1'b1, NO_SAMPLE},
        '{ROW_WRITE, REG_WINDOW_START,  64'hFFFF_FFF0,          1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 64'hFFFF_FFFF,          1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_START_FREQ,    64'h7FFF_FFFF,          1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_HALF_RATE,     64'h8000_0000_0000_0000, 1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_AMPLITUDE,     64'hFFFF,               1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'hFFFF_FFEF,          1'b1, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'hFFFF_FFF0,          1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'hFFFF_FFFF,          1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'd0,                  1'b1, NO_SAMPLE},
        '{ROW_WRITE, REG_WINDOW_START,  64'd5,                  1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 64'd0,                  1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'd5,                  1'b1, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'd0,                  1'b1, NO_SAMPLE},
        '{ROW_WRITE, REG_WINDOW_START,  64'd0,                  1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 64'hFFFF_FFFF,          1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_START_FREQ,    64'h8000_0000,          1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_HALF_RATE,     64'h7FFF_FFFF_FFFF_FFFF, 1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_AMPLITUDE,     64'd0,                  1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'hFFFF_FFFE,          1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'd12345,              1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_AMPLITUDE,     64'd4096,               1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_START_FREQ,    64'd0,                  1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_HALF_RATE,     64'd1,                  1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_SPARE_LOW,     64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_SAMPLE},
        '{ROW_WRITE, REG_SPARE_HIGH,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'h0001_0000,          1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'hFFFF_FFFE,          1'b0, NO_SAMPLE},
        '{ROW_TIME,  NO_REG,            64'd7,                  1'b0, NO_SAMPLE}
    };

    lfm_chirp_sample_generator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Amplitude scaling of a Q2.30 value to Q4.15 with round half up and saturation.
    function automatic logic [SAMPLE_BITS-1:0] scale_to_q415(input longint trig);
        longint r;
        r = (trig * longint'(cur_amp) + (longint'(1) <<< 26)) >>> 27;
        if (r > SAT_HI)
            r = SAT_HI;
        else if (r < SAT_LO)
            r = SAT_LO;
        return r[SAMPLE_BITS-1:0];
    endfunction

    function automatic sample_t chirp_sample(input logic [31:0] t);
        sample_t     res;
        logic [63:0] tau;
        logic [63:0] freq_ext;
        logic [63:0] phase;
        logic [31:0] kept;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        longint      c_out;
        longint      s_out;
        res = NO_SAMPLE;
        if (t < cur_start || (t - cur_start) >= cur_length)
            return res;
        tau      = {32'd0, t - cur_start};
        freq_ext = {{32{cur_freq[31]}}, cur_freq};
        phase    = ((freq_ext * tau) << 32) + cur_half_rate * (tau * tau);
        // Only the quadrant bits and the table address survive truncation.
        kept = {phase[63:64-PHASE_KEEP], {(32 - PHASE_KEEP){1'b0}}};
        x = X_START;
        y = 0;
        z = longint'(kept[29:0]);
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARC_TURNS[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARC_TURNS[i];
            end
        end
        case (kept[31:30])
            QUAD_I:
            begin
                c_out = x;
                s_out = y;
            end
            QUAD_II:
            begin
                c_out = -y;
                s_out = x;
            end
            QUAD_III:
            begin
                c_out = -x;
                s_out = -y;
            end
            default:
            begin
                c_out = y;
                s_out = -x;
            end
        endcase
        res.in_phase   = scale_to_q415(c_out);
        res.quadrature = scale_to_q415(s_out);
        res.active     = 1'b1;
        return res;
    endfunction

    // Mostly times inside the window, some at its edges, the rest anywhere.
    function automatic logic [31:0] pick_time();
        logic [32:0] span;
        logic [32:0] lim;
        logic [31:0] last;
        int          pick;
        span = 33'h1_0000_0000 - {1'b0, cur_start};
        if ({1'b0, cur_length} < span)
            span = {1'b0, cur_length};
        if (span == 33'd0)
            return $urandom;
        lim  = span - 33'd1;
        last = cur_start + lim[31:0];
        pick = $urandom_range(99);
        if (pick < 70)
            return cur_start + $urandom_range(lim[31:0], 0);
        if (pick < 85)
        begin
            case ($urandom_range(3))
                0: return cur_start - 32'd1;
                1: return cur_start;
                2: return last;
                default: return last + 32'd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_WINDOW_START:  cur_start = value[31:0];
            REG_WINDOW_LENGTH: cur_length = value[31:0];
            REG_START_FREQ:    cur_freq = value[31:0];
            REG_HALF_RATE:     cur_half_rate = value;
            REG_AMPLITUDE:     cur_amp = value[15:0];
            default:           ;
        endcase
        reg_writes++;
    endtask

    task automatic cfg_bus_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic offer_time(input logic [31:0] t, input logic typed, input sample_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        do
            @(posedge clk);
        while (!s_tready);
        samples_due.push_back(typed ? want : chirp_sample(t));
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (samples_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic load_setting(input int ph);
        logic [31:0] st;
        logic [31:0] len;
        logic [31:0] fr;
        logic [63:0] hr;
        logic [15:0] am;
        case (ph)
            0:
            begin
                st = 32'd0;
                len = 32'hFFFF_FFFF;
                fr = 32'h8000_0000;
                hr = 64'h8000_0000_0000_0000;
                am = 16'hFFFF;
            end
            1:
            begin
                st = 32'hFFFF_FFFF - $urandom_range(400);
                len = 32'hFFFF_FFFF;
                fr = 32'h7FFF_FFFF;
                hr = 64'h7FFF_FFFF_FFFF_FFFF;
                am = 16'd1;
            end
            2:
            begin
                // A slow sweep of the kind software would actually load.
                st = $urandom;
                len = $urandom_range(2000, 200);
                fr = $urandom >> 6;
                hr = 64'($urandom);
                am = 16'd4096;
            end
            default:
            begin
                case ($urandom_range(2))
                    0: st = 32'd0;
                    1: st = $urandom;
                    default: st = 32'hFFFF_FFFF - $urandom_range(2000);
                endcase
                case ($urandom_range(3))
                    0: len = 32'd1;
                    1: len = $urandom_range(64, 2);
                    2: len = 32'hFFFF_FFFF;
                    default: len = $urandom;
                endcase
                fr = $urandom;
                hr = {$urandom, $urandom};
                am = 16'($urandom);
            end
        endcase
        cfg_write(REG_WINDOW_START, {32'd0, st});
        cfg_write(REG_WINDOW_LENGTH, {32'd0, len});
        cfg_write(REG_START_FREQ, {32'd0, fr});
        cfg_write(REG_HALF_RATE, hr);
        cfg_write(REG_AMPLITUDE, {48'd0, am});
        cfg_bus_idle();
    endtask

    // Output backpressure: random stalls, or a long hold-off when the driver asks for one.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_taken != hold_asked)
        begin
            hold_taken <= hold_asked;
            hold_left  <= LONG_HOLD;
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        sample_t want;
        sample_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.in_phase   = m_tdata[SAMPLE_BITS-1:0];
            got.quadrature = m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            got.active     = m_tuser[0];
            if (samples_due.size() == 0)
            begin
                $error("sample transfer with nothing expected");
                fails++;
            end
            else
            begin
                want = samples_due.pop_front();
                checked++;
                if (got.in_phase !== want.in_phase)
                begin
                    $error("in_phase: expected %0d, got %0d",
                           $signed(want.in_phase), $signed(got.in_phase));
                    fails++;
                end
                if (got.quadrature !== want.quadrature)
                begin
                    $error("quadrature: expected %0d, got %0d",
                           $signed(want.quadrature), $signed(got.quadrature));
                    fails++;
                end
                if (got.active !== want.active)
                begin
                    $error("active: expected %0d, got %0d", want.active, got.active);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        int gap_pct;
        gap_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int k = 0; k < N_ROWS; k++)
        begin
            if (directed_rows[k].kind == ROW_WRITE)
            begin
                wait_for_drain();
                cfg_write(directed_rows[k].idx, directed_rows[k].value);
                cfg_bus_idle();
            end
            else
            begin
                offer_time(directed_rows[k].value[31:0], directed_rows[k].typed,
                           directed_rows[k].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_for_drain();
            load_setting(ph);
            // Handshake mix: none, sender gaps, receiver stalls, then both lightly.
            case (ph % 4)
                0:
                begin
                    gap_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    gap_pct = 69;
                    stall_pct <= 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct <= 69;
                end
                default:
                begin
                    gap_pct = 21;
                    stall_pct <= 21;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 4 && n == 10)
                    hold_asked <= hold_asked + 1;
                if (ph == 5 && n == 110)
                    wait_for_drain();
                while ($urandom_range(99) < gap_pct)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                end
                offer_time(pick_time(), 1'b0, NO_SAMPLE);
            end
        end

        s_tvalid <= 1'b0;
        while (samples_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Run covered %0d samples checked across %0d register writes, window edges,",
                 checked, reg_writes);
        $display("extreme rates and amplitudes, mixed backpressure and a long output stall.");
        if (fails == 0 && samples_due.size() == 0)
            $display("** lfm_chirp_sample_generator: PASSED **");
        else
            $display("** lfm_chirp_sample_generator: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("** lfm_chirp_sample_generator: FAILED **");
        $finish;
    end

endmodule
